// File: hw/rtl/srp_pkg.sv
// Shared types, codes and constants of the servo reply parser.
`timescale 1ns / 1ps
package srp_pkg;

   localparam int TICK_BITS    = 16;
   localparam int TIMEOUT_W    = 16;
   localparam int TICK_CMP_W   = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ID      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_COMMAND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARAM_CAPACITY   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS    = 2'd3;

   localparam logic [7:0]  HDR_BYTE     = 8'h55;
   localparam logic [7:0]  ANY_ID       = 8'hfe;
   localparam logic [3:0]  IDLE_LENGTH  = 4'd7;
   localparam logic [7:0]  RST_ID       = 8'hfe;
   localparam logic [7:0]  RST_COMMAND  = 8'h00;
   localparam logic [2:0]  RST_CAPACITY = 3'd4;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 16'd1000;

   localparam logic KIND_PARAM  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_HEADER   = 4'd1,
      ST_ID       = 4'd2,
      ST_LENGTH   = 4'd3,
      ST_TOO_LONG = 4'd4,
      ST_COMMAND  = 4'd5,
      ST_CHECKSUM = 4'd6,
      ST_TIMEOUT  = 4'd7,
      ST_OVERFLOW = 4'd8
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] param_index;
      logic [7:0] param_value;
      status_type status;
      logic [2:0] param_count;
   } result_type;

endpackage

// File: hw/rtl/srp_frame_core.sv
// Input register, frame state and per-beat parse logic of the reply parser.
`timescale 1ns / 1ps
module srp_frame_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          csr_we,
   input  logic [srp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                          room,
   output logic                          push,
   output srp_pkg::result_type           result
);
   import srp_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           mode_ff;
   logic [7:0]           byte_ff;

   logic [7:0]           exp_id_ff;
   logic [7:0]           exp_cmd_ff;
   logic [2:0]           capacity_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic                 active_ff, active_in;
   logic [3:0]           pos_ff, pos_in;
   logic [3:0]           length_ff, length_in;
   logic [7:0]           sum_ff, sum_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;

   logic                 accept, proc;
   logic [2:0]           count;
   logic [TICK_BITS-1:0] ticks_next;
   logic [4:0]           limit;

   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign proc      = in_valid_ff && room;
   assign count     = (pos_ff > 4'd5) ? 3'(pos_ff - 4'd5) : 3'd0;
   assign ticks_next = (ticks_ff == {TICK_BITS{1'b1}}) ? ticks_ff : ticks_ff + 1'b1;
   assign limit     = {2'b00, capacity_ff} + 5'd6;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (proc ? 1'b0 : in_valid_ff);
   end

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      ticks_in  = ticks_ff;
      push      = 1'b0;
      result    = '0;
      if (proc) begin
         case (mode_ff)
            MODE_START: begin
               active_in = 1'b1;
               pos_in    = 4'd0;
               length_in = IDLE_LENGTH;
               sum_in    = 8'd0;
               ticks_in  = '0;
            end
            MODE_TICK: begin
               if (active_ff) begin
                  ticks_in = ticks_next;
                  if (TICK_CMP_W'(ticks_next) >= TICK_CMP_W'(timeout_ff) ||
                      ticks_next == {TICK_BITS{1'b1}}) begin
                     push               = 1'b1;
                     result.kind        = KIND_STATUS;
                     result.status      = ST_TIMEOUT;
                     result.param_count = count;
                     active_in          = 1'b0;
                  end
               end
            end
            MODE_BYTE: begin
               if (active_ff) begin
                  if (pos_ff <= 4'd1) begin
                     if (byte_ff != HDR_BYTE) begin
                        push = 1'b1; result.kind = KIND_STATUS;
                        result.status = ST_HEADER; active_in = 1'b0;
                     end else begin
                        pos_in = pos_ff + 4'd1;
                     end
                  end else if (pos_ff == 4'd2) begin
                     if (byte_ff != exp_id_ff && exp_id_ff != ANY_ID) begin
                        push = 1'b1; result.kind = KIND_STATUS;
                        result.status = ST_ID; active_in = 1'b0;
                     end else begin
                        sum_in = sum_ff + byte_ff;
                        pos_in = pos_ff + 4'd1;
                     end
                  end else if (pos_ff == 4'd3) begin
                     if (byte_ff < 8'd3 || byte_ff > 8'd7) begin
                        push = 1'b1; result.kind = KIND_STATUS;
                        result.status = ST_LENGTH; active_in = 1'b0;
                     end else begin
                        length_in = byte_ff[3:0] + 4'd3;
                        if ({1'b0, length_in} > limit) begin
                           push = 1'b1; result.kind = KIND_STATUS;
                           result.status = ST_TOO_LONG; active_in = 1'b0;
                        end else begin
                           sum_in = sum_ff + byte_ff;
                           pos_in = pos_ff + 4'd1;
                        end
                     end
                  end else if (pos_ff == 4'd4) begin
                     if (byte_ff != exp_cmd_ff) begin
                        push = 1'b1; result.kind = KIND_STATUS;
                        result.status = ST_COMMAND; active_in = 1'b0;
                     end else begin
                        sum_in = sum_ff + byte_ff;
                        pos_in = pos_ff + 4'd1;
                     end
                  end else if ({1'b0, pos_ff} + 5'd1 >= {1'b0, length_ff}) begin
                     // checksum byte closes the frame
                     push               = 1'b1;
                     result.kind        = KIND_STATUS;
                     result.status      = (byte_ff == ~sum_ff) ? ST_OK : ST_CHECKSUM;
                     result.param_count = count;
                     active_in          = 1'b0;
                  end else if (count >= capacity_ff || count >= 3'd4) begin
                     push               = 1'b1;
                     result.kind        = KIND_STATUS;
                     result.status      = ST_OVERFLOW;
                     result.param_count = count;
                     active_in          = 1'b0;
                  end else begin
                     push               = 1'b1;
                     result.kind        = KIND_PARAM;
                     result.param_index = count[1:0];
                     result.param_value = byte_ff;
                     sum_in             = sum_ff + byte_ff;
                     pos_in             = pos_ff + 4'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         active_ff   <= 1'b0;
         pos_ff      <= 4'd0;
         length_ff   <= IDLE_LENGTH;
         sum_ff      <= 8'd0;
         ticks_ff    <= '0;
         exp_id_ff   <= RST_ID;
         exp_cmd_ff  <= RST_COMMAND;
         capacity_ff <= RST_CAPACITY;
         timeout_ff  <= RST_TIMEOUT;
      end else begin
         in_valid_ff <= in_valid_in;
         active_ff   <= active_in;
         pos_ff      <= pos_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         ticks_ff    <= ticks_in;
         if (csr_we) begin
            case (csr_index)
               CSR_EXPECTED_ID:      exp_id_ff   <= csr_wdata[7:0];
               CSR_EXPECTED_COMMAND: exp_cmd_ff  <= csr_wdata[7:0];
               CSR_PARAM_CAPACITY:   capacity_ff <= csr_wdata[2:0];
               CSR_TIMEOUT_TICKS:    timeout_ff  <= csr_wdata[TIMEOUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         byte_ff <= req_rx_byte;
      end
   end

`ifndef SYNTHESIS
   a_result_needs_frame: assert property (@(posedge clock) disable iff (reset)
      push |-> active_ff)
      else $error("result raised outside an open frame");
   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      (push && result.kind == KIND_STATUS) |=> !active_ff)
      else $error("frame still open after its status beat");
   a_param_advances: assert property (@(posedge clock) disable iff (reset)
      (push && result.kind == KIND_PARAM) |=> pos_ff == $past(pos_ff) + 4'd1)
      else $error("parameter beat did not advance the byte position");
`endif

endmodule

// File: hw/rtl/srp_out_queue.sv
// Two-entry result queue that decouples the parser from the response stall.
`timescale 1ns / 1ps
module srp_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  srp_pkg::result_type push_data,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srp_pkg::result_type rsp_data
);
   import srp_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff != 2'd2;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: hw/rtl/servo_reply_parser_unit.sv
// Top level of the servo bus reply frame parser.
`timescale 1ns / 1ps
// Usage
//   req_ channel: one beat per received byte (mode 0), time tick (mode 1) or
//   start of a new reply (mode 2). Mode 3 beats are taken and dropped.
//   rsp_ channel: at most one beat per request beat, either a parameter byte
//   (kind 0) or the single closing status of the frame (kind 1).
//   csr_ port: write expected ID, expected command, parameter capacity and
//   timeout while the parser is idle; no read-back.
// Timing
//   A request beat lands in the input register, is parsed there by the
//   combinational frame logic and its result is written to a two-entry
//   output queue, from which the response is offered. One beat per cycle is
//   sustained while the queue has room; the rate is set by the single parse
//   pass between input register and queue.
// Stall
//   When the receiver stalls, results hold in the queue; once both entries
//   are full the parsed beat holds in the input register and req_stall rises.
// Reset
//   Synchronous reset closes any frame, empties the queue and loads the
//   register defaults: ID 254 (any), command 0, capacity 4, timeout 1000.
module servo_reply_parser_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [1:0]                      rsp_param_index,
   output logic [7:0]                      rsp_param_value,
   output logic [3:0]                      rsp_status,
   output logic [2:0]                      rsp_param_count,
   input  logic                            csr_we,
   input  logic [srp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srp_pkg::*;

   logic       room;
   logic       push;
   result_type result;
   result_type rsp_data;

   // parse stage: input register, frame state and configuration
   srp_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .room        (room),
      .push        (push),
      .result      (result)
   );

   // result register pair: holds beats while the receiver stalls
   srp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_param_index = rsp_data.param_index;
   assign rsp_param_value = rsp_data.param_value;
   assign rsp_status      = rsp_data.status;
   assign rsp_param_count = rsp_data.param_count;

endmodule
